### rtl/core/spids_pkg.sv
// Shared types and constants for the speed PI drive scheduler.
package spids_pkg;

  localparam int unsigned DIV_BITS = 48;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS);

  localparam logic signed [63:0] DRIVE_SAT = 64'sd1 <<< 46;

  typedef enum logic [2:0] {
    REG_SET_SPEED      = 3'd0,
    REG_GAIN_P         = 3'd1,
    REG_GAIN_I         = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_SPEED_LOW      = 3'd4,
    REG_SPEED_HIGH     = 3'd5,
    REG_BLEND_ZONE     = 3'd6,
    REG_MID_DRIVE_CAP  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [14:0]        set_speed;
    logic [15:0]        gain_p;
    logic [15:0]        gain_i;
    logic [30:0]        integral_limit;
    logic [14:0]        speed_low;
    logic [14:0]        speed_high;
    logic [14:0]        blend_zone;
    logic signed [15:0] mid_drive_cap;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INTEG,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_XL,
    OP_MUL_XH,
    OP_ACC_SET,
    OP_ACC_ADD,
    OP_ACC_ADD_HI,
    OP_SAT,
    OP_PREP_LO,
    OP_PREP_HI,
    OP_FORCE_LO,
    OP_FORCE_HI,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_APPLY,
    OP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    logic inh;
    logic lo_force;
    logic lo_blend;
    logic hi_force;
    logic hi_blend;
    logic div_last;
  } dp_status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INTEG,
    ST_MUL_P,
    ST_ACC_P,
    ST_MUL_I,
    ST_ACC_I,
    ST_SAT,
    ST_FORCE_LO,
    ST_PREP_LO,
    ST_MUL_XL,
    ST_ACC_XL,
    ST_MUL_XH,
    ST_ACC_XH,
    ST_DIV_INIT,
    ST_DIV,
    ST_APPLY,
    ST_FORCE_HI,
    ST_PREP_HI,
    ST_FINISH
  } ctrl_state_t;

endpackage

### rtl/core/spids_cfg.sv
// Configuration register file for the speed PI drive scheduler.
module spids_cfg import spids_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SET_SPEED:      cfg_nxt.set_speed      = cfg_data[14:0];
        REG_GAIN_P:         cfg_nxt.gain_p         = cfg_data[15:0];
        REG_GAIN_I:         cfg_nxt.gain_i         = cfg_data[15:0];
        REG_INTEGRAL_LIMIT: cfg_nxt.integral_limit = cfg_data[30:0];
        REG_SPEED_LOW:      cfg_nxt.speed_low      = cfg_data[14:0];
        REG_SPEED_HIGH:     cfg_nxt.speed_high     = cfg_data[14:0];
        REG_BLEND_ZONE:     cfg_nxt.blend_zone     = cfg_data[14:0];
        REG_MID_DRIVE_CAP:  cfg_nxt.mid_drive_cap  = $signed(cfg_data[15:0]);
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.set_speed      <= '0;
      cfg_r.gain_p         <= '0;
      cfg_r.gain_i         <= '0;
      cfg_r.integral_limit <= '0;
      cfg_r.speed_low      <= '0;
      cfg_r.speed_high     <= 15'h7FFF;
      cfg_r.blend_zone     <= '0;
      cfg_r.mid_drive_cap  <= 16'sh7FFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/core/spids_dp.sv
// Datapath: integral, shared multiplier and accumulator, blend divider, output word.
module spids_dp import spids_pkg::*; #(
  parameter int unsigned LOW_SPEED_DRIVE  = 40,
  parameter int unsigned HIGH_SPEED_DRIVE = 20,
  parameter int unsigned PEDAL_FLOOR      = 0,
  parameter int unsigned PEDAL_CEIL       = 100
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  dp_op_t             op,
  input  logic signed [15:0] in_speed,
  input  logic               in_inhibit,
  output dp_status_t         status,
  output logic [7:0]         out_pedal_command,
  output logic               out_drive_valid,
  output logic               out_integral_frozen
);

  localparam logic signed [47:0] LOW_S  = 48'(LOW_SPEED_DRIVE) << 16;
  localparam logic signed [47:0] HIGH_S = 48'(HIGH_SPEED_DRIVE) << 16;
  localparam logic [31:0]        P_MIN  = 32'(PEDAL_FLOOR);
  localparam logic [31:0]        P_MAX  = 32'(PEDAL_CEIL);

  // registers
  logic signed [15:0]    v_r, v_nxt;
  logic                  inh_r, inh_nxt;
  logic signed [31:0]    integral_r, integral_nxt;
  logic signed [49:0]    prod_r, prod_nxt;
  logic signed [63:0]    acc_r, acc_nxt;
  logic signed [47:0]    d_r, d_nxt;
  logic signed [47:0]    base_r, base_nxt;
  logic signed [47:0]    x_r, x_nxt;
  logic [14:0]           t_r, t_nxt;
  logic [14:0]           rem_r, rem_nxt;
  logic [47:0]           dvd_r, dvd_nxt;
  logic                  neg_r, neg_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]            pedal_r, pedal_nxt;
  logic                  dvalid_r, dvalid_nxt;
  logic                  frozen_r, frozen_nxt;

  // band edges and error
  logic signed [17:0] v_w, zone_w, lo_hi_w, lo_lo_w, hi_lo_w, hi_hi_w, err_w;
  logic               frozen_w, mid_w;
  logic signed [33:0] sum_w, lim_w;
  logic signed [16:0] mul_a_w;
  logic signed [32:0] mul_b_w;
  logic signed [63:0] prod64_w, mag_w;
  logic [15:0]        trial_w;
  logic               ge_w;
  logic signed [47:0] q_w, cap_w, dcap_w;
  logic [31:0]        pq_w;

  always_comb begin
    v_w      = {{2{v_r[15]}}, v_r};
    zone_w   = $signed({3'b000, cfg.blend_zone});
    lo_hi_w  = $signed({3'b000, cfg.speed_low});
    hi_lo_w  = $signed({3'b000, cfg.speed_high});
    lo_lo_w  = lo_hi_w - zone_w;
    hi_hi_w  = hi_lo_w + zone_w;
    err_w    = $signed({3'b000, cfg.set_speed}) - v_w;
    frozen_w = (v_w <= lo_lo_w) || (v_w >= hi_hi_w);
    mid_w    = (v_w > lo_hi_w) && (v_w < hi_lo_w);

    sum_w = {{2{integral_r[31]}}, integral_r} + {{16{err_w[17]}}, err_w};
    lim_w = $signed({3'b000, cfg.integral_limit});

    mul_a_w = '0;
    mul_b_w = '0;
    unique case (op)
      OP_MUL_P: begin
        mul_a_w = $signed({1'b0, cfg.gain_p});
        mul_b_w = {{15{err_w[17]}}, err_w};
      end
      OP_MUL_I: begin
        mul_a_w = $signed({1'b0, cfg.gain_i});
        mul_b_w = {integral_r[31], integral_r};
      end
      OP_MUL_XL: begin
        mul_a_w = $signed({2'b00, t_r});
        mul_b_w = $signed({9'h000, x_r[23:0]});
      end
      OP_MUL_XH: begin
        mul_a_w = $signed({2'b00, t_r});
        mul_b_w = {{9{x_r[47]}}, x_r[47:24]};
      end
      default: begin
        mul_a_w = '0;
        mul_b_w = '0;
      end
    endcase

    prod64_w = {{14{prod_r[49]}}, prod_r};
    mag_w    = acc_r[63] ? -acc_r : acc_r;
    trial_w  = {rem_r, dvd_r[47]};
    ge_w     = trial_w >= {1'b0, cfg.blend_zone};
    q_w      = neg_r ? -$signed(dvd_r) : $signed(dvd_r);

    cap_w  = {{16{cfg.mid_drive_cap[15]}}, cfg.mid_drive_cap, 16'h0000};
    dcap_w = (mid_w && (d_r > cap_w)) ? cap_w : d_r;
    pq_w   = dcap_w[47:16];
  end

  always_comb begin
    v_nxt        = v_r;
    inh_nxt      = inh_r;
    integral_nxt = integral_r;
    prod_nxt     = prod_r;
    acc_nxt      = acc_r;
    d_nxt        = d_r;
    base_nxt     = base_r;
    x_nxt        = x_r;
    t_nxt        = t_r;
    rem_nxt      = rem_r;
    dvd_nxt      = dvd_r;
    neg_nxt      = neg_r;
    cnt_nxt      = cnt_r;
    pedal_nxt    = pedal_r;
    dvalid_nxt   = dvalid_r;
    frozen_nxt   = frozen_r;

    unique case (op)
      OP_LOAD: begin
        v_nxt   = in_speed;
        inh_nxt = in_inhibit;
      end
      OP_INTEG: begin
        if (inh_r) begin
          integral_nxt = '0;
        end else if (!frozen_w) begin
          priority if (sum_w > lim_w) begin
            integral_nxt = lim_w[31:0];
          end else if (sum_w < -lim_w) begin
            integral_nxt = 32'(-lim_w);
          end else begin
            integral_nxt = sum_w[31:0];
          end
        end
      end
      OP_MUL_P, OP_MUL_I, OP_MUL_XL, OP_MUL_XH: begin
        prod_nxt = mul_a_w * mul_b_w;
      end
      OP_ACC_SET:    acc_nxt = prod64_w;
      OP_ACC_ADD:    acc_nxt = acc_r + prod64_w;
      OP_ACC_ADD_HI: acc_nxt = acc_r + $signed({prod64_w[39:0], 24'h000000});
      OP_SAT: begin
        priority if (acc_r > DRIVE_SAT) begin
          d_nxt = DRIVE_SAT[47:0];
        end else if (acc_r < -DRIVE_SAT) begin
          d_nxt = 48'(-DRIVE_SAT);
        end else begin
          d_nxt = acc_r[47:0];
        end
      end
      OP_PREP_LO: begin
        base_nxt = LOW_S;
        x_nxt    = d_r - LOW_S;
        t_nxt    = 15'(v_w - lo_lo_w);
      end
      OP_PREP_HI: begin
        base_nxt = d_r;
        x_nxt    = HIGH_S - d_r;
        t_nxt    = 15'(v_w - hi_lo_w);
      end
      OP_FORCE_LO: d_nxt = LOW_S;
      OP_FORCE_HI: d_nxt = HIGH_S;
      OP_DIV_INIT: begin
        // product magnitude stays below zone * 2^48, so the top part is a valid remainder
        neg_nxt = acc_r[63];
        rem_nxt = mag_w[62:48];
        dvd_nxt = mag_w[47:0];
        cnt_nxt = '0;
      end
      OP_DIV_STEP: begin
        rem_nxt = ge_w ? 15'(trial_w - {1'b0, cfg.blend_zone}) : trial_w[14:0];
        dvd_nxt = {dvd_r[46:0], ge_w};
        cnt_nxt = cnt_r + 1'b1;
      end
      OP_APPLY: d_nxt = base_r + q_w;
      OP_OUT_LOAD: begin
        if (inh_r) begin
          pedal_nxt  = '0;
          dvalid_nxt = 1'b0;
          frozen_nxt = 1'b0;
        end else begin
          dvalid_nxt = 1'b1;
          frozen_nxt = frozen_w;
          // a negative drive truncates to zero or less and so lands on the floor
          priority if (dcap_w < 0) begin
            pedal_nxt = P_MIN[7:0];
          end else if (pq_w < P_MIN) begin
            pedal_nxt = P_MIN[7:0];
          end else if (pq_w > P_MAX) begin
            pedal_nxt = P_MAX[7:0];
          end else begin
            pedal_nxt = pq_w[7:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
      cnt_r      <= '0;
    end else begin
      integral_r <= integral_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r      <= v_nxt;
    inh_r    <= inh_nxt;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    d_r      <= d_nxt;
    base_r   <= base_nxt;
    x_r      <= x_nxt;
    t_r      <= t_nxt;
    rem_r    <= rem_nxt;
    dvd_r    <= dvd_nxt;
    neg_r    <= neg_nxt;
    pedal_r  <= pedal_nxt;
    dvalid_r <= dvalid_nxt;
    frozen_r <= frozen_nxt;
  end

  assign status.inh      = inh_r;
  assign status.lo_force = v_w <= lo_lo_w;
  assign status.lo_blend = (cfg.blend_zone != '0) && (v_w < lo_hi_w);
  assign status.hi_force = v_w >= hi_hi_w;
  assign status.hi_blend = (cfg.blend_zone != '0) && (v_w > hi_lo_w);
  assign status.div_last = cnt_r == DIV_CNT_W'(DIV_BITS - 1);

  assign out_pedal_command   = pedal_r;
  assign out_drive_valid     = dvalid_r;
  assign out_integral_frozen = frozen_r;

endmodule

### rtl/core/spids_ctrl.sv
// Sequencer: steps the datapath through PI, low blend, high blend and output.
module spids_ctrl import spids_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_op_t     op
);

  ctrl_state_t state_r, state_nxt;
  logic        phase_hi_r, phase_hi_nxt;
  logic        out_valid_r, out_valid_nxt;
  ctrl_state_t hi_next;

  assign out_valid = out_valid_r;

  always_comb begin
    priority if (status.hi_force) begin
      hi_next = ST_FORCE_HI;
    end else if (status.hi_blend) begin
      hi_next = ST_PREP_HI;
    end else begin
      hi_next = ST_FINISH;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_hi_nxt  = phase_hi_r;
    out_valid_nxt = out_valid_r && out_stall;
    op            = OP_NONE;
    in_stall      = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = ST_INTEG;
        end
      end
      ST_INTEG: begin
        op        = OP_INTEG;
        state_nxt = status.inh ? ST_FINISH : ST_MUL_P;
      end
      ST_MUL_P: begin
        op        = OP_MUL_P;
        state_nxt = ST_ACC_P;
      end
      ST_ACC_P: begin
        op        = OP_ACC_SET;
        state_nxt = ST_MUL_I;
      end
      ST_MUL_I: begin
        op        = OP_MUL_I;
        state_nxt = ST_ACC_I;
      end
      ST_ACC_I: begin
        op        = OP_ACC_ADD;
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        op = OP_SAT;
        priority if (status.lo_force) begin
          state_nxt = ST_FORCE_LO;
        end else if (status.lo_blend) begin
          state_nxt = ST_PREP_LO;
        end else begin
          state_nxt = hi_next;
        end
      end
      ST_FORCE_LO: begin
        op        = OP_FORCE_LO;
        state_nxt = hi_next;
      end
      ST_PREP_LO: begin
        op           = OP_PREP_LO;
        phase_hi_nxt = 1'b0;
        state_nxt    = ST_MUL_XL;
      end
      ST_PREP_HI: begin
        op           = OP_PREP_HI;
        phase_hi_nxt = 1'b1;
        state_nxt    = ST_MUL_XL;
      end
      ST_MUL_XL: begin
        op        = OP_MUL_XL;
        state_nxt = ST_ACC_XL;
      end
      ST_ACC_XL: begin
        op        = OP_ACC_SET;
        state_nxt = ST_MUL_XH;
      end
      ST_MUL_XH: begin
        op        = OP_MUL_XH;
        state_nxt = ST_ACC_XH;
      end
      ST_ACC_XH: begin
        op        = OP_ACC_ADD_HI;
        state_nxt = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        op        = OP_DIV_INIT;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        op = OP_DIV_STEP;
        if (status.div_last) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        op        = OP_APPLY;
        state_nxt = phase_hi_r ? ST_FINISH : hi_next;
      end
      ST_FORCE_HI: begin
        op        = OP_FORCE_HI;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output word slot is free
        if (!out_valid_r || !out_stall) begin
          op            = OP_OUT_LOAD;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_hi_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_hi_r  <= phase_hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/core/speed_pi_drive_scheduler_core.sv
// From input word to output word the sequencer runs the PI terms, then each blend zone
// in use or a forced low or high drive; an inhibited word clears the integral and goes to the output.
// Each blend runs a 48-step restoring divider. A new input word is taken only once the last
// result is loaded into the output word, and it is taken while that result waits.
// The PI terms and blend products share one 17x33 multiplier.
// Synchronous reset clears the integral, sequencer and output valid, loads config defaults.
module speed_pi_drive_scheduler_core import spids_pkg::*; #(
  parameter int unsigned LOW_SPEED_DRIVE  = 40,
  parameter int unsigned HIGH_SPEED_DRIVE = 20,
  parameter int unsigned PEDAL_FLOOR      = 0,
  parameter int unsigned PEDAL_CEIL       = 100
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_speed,
  input  logic               in_inhibit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_pedal_command,
  output logic               out_drive_valid,
  output logic               out_integral_frozen,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t       cfg;
  dp_op_t     op;
  dp_status_t status;

  spids_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  spids_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .op        (op)
  );

  spids_dp #(
    .LOW_SPEED_DRIVE  (LOW_SPEED_DRIVE),
    .HIGH_SPEED_DRIVE (HIGH_SPEED_DRIVE),
    .PEDAL_FLOOR      (PEDAL_FLOOR),
    .PEDAL_CEIL       (PEDAL_CEIL)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .op                  (op),
    .in_speed            (in_speed),
    .in_inhibit          (in_inhibit),
    .status              (status),
    .out_pedal_command   (out_pedal_command),
    .out_drive_valid     (out_drive_valid),
    .out_integral_frozen (out_integral_frozen)
  );

endmodule
